// File: src/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// Types and constants shared by the curve subdivision stream modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csd_pkg;

   localparam int SLOTS = 4;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int POINT_SLOTS = 10;

   localparam logic SCHEME_BSPLINE    = 1'b0;
   localparam logic SCHEME_FOUR_POINT = 1'b1;

   typedef enum logic [2:0] {
      OP_POINT,
      OP_PREV,
      OP_MID,
      OP_SMOOTH,
      OP_INS_LO,
      OP_INS_HI
   } op_type;

   typedef struct packed {
      op_type [SLOTS-1:0] ops;
      logic   [IDX_W-1:0] final_idx;
      logic               last;
   } cmd_type;

endpackage

// File: src/csd_req_if.sv
// ----------------------------------------------------------------------------
// csd_req_if
// Control point channel: valid, ready and one control point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface csd_req_if #(parameter int COORD_WIDTH = 24);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          point_last;

   modport source (output valid, point_x, point_y, point_last, input ready);
   modport sink (input valid, point_x, point_y, point_last, output ready);
endinterface

// File: src/csd_rsp_if.sv
// ----------------------------------------------------------------------------
// csd_rsp_if
// Refined point channel: valid, ready and one refined point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface csd_rsp_if #(parameter int COORD_WIDTH = 24);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic                          out_last;

   modport source (output valid, out_x, out_y, out_last, input ready);
   modport sink (input valid, out_x, out_y, out_last, output ready);
endinterface

// File: src/csd_csr_if.sv
// ----------------------------------------------------------------------------
// csd_csr_if
// Configuration write channel for the subdivision scheme register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface csd_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: src/csd_front.sv
// ----------------------------------------------------------------------------
// csd_front
// Accepts control points, keeps the point window and builds one command per
// item that yields refined points, listing the refined points it produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csd_front
   import csd_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                       clock,
   input  logic                                       reset,
   csd_req_if.sink                                    req_bus,
   csd_csr_if.sink                                    csr_bus,
   output logic                                       push_valid,
   output cmd_type                                    push_cmd,
   output logic [POINT_SLOTS*(COORD_WIDTH+2)-1:0]     push_data,
   input  logic                                       push_ready
);

   localparam int E = COORD_WIDTH + 2;

   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE  = 2'd1;
   localparam logic [1:0] SEEN_TWO  = 2'd2;
   localparam logic [1:0] SEEN_MANY = 2'd3;

   logic signed [COORD_WIDTH-1:0] win_x_ff [3];
   logic signed [COORD_WIDTH-1:0] win_y_ff [3];
   logic [1:0] seen_ff, seen_in;
   logic       scheme_ff, scheme_in;

   logic accept;
   logic signed [E-1:0] px, py, w0x, w0y, w1x, w1y, w2x, w2y;
   logic signed [E-1:0] ax, ay, gx, gy;

   assign req_bus.ready = push_ready;
   assign csr_bus.ready = 1'b1;
   assign accept = req_bus.valid && push_ready;

   assign px  = E'(req_bus.point_x);
   assign py  = E'(req_bus.point_y);
   assign w0x = E'(win_x_ff[0]);
   assign w0y = E'(win_y_ff[0]);
   assign w1x = E'(win_x_ff[1]);
   assign w1y = E'(win_y_ff[1]);
   assign w2x = E'(win_x_ff[2]);
   assign w2y = E'(win_y_ff[2]);

   assign ax = (seen_ff == SEEN_TWO) ? (w1x <<< 1) - w0x : w2x;
   assign ay = (seen_ff == SEEN_TWO) ? (w1y <<< 1) - w0y : w2y;
   assign gx = (px <<< 1) - w0x;
   assign gy = (py <<< 1) - w0y;

   assign push_data = {gy, gx, py, px, w0y, w0x, w1y, w1x, ay, ax};

   always_comb begin
      push_cmd.ops       = {SLOTS{OP_POINT}};
      push_cmd.final_idx = '0;
      push_cmd.last      = req_bus.point_last;
      push_valid         = req_bus.valid;
      if (seen_ff == SEEN_NONE) begin
         push_cmd.ops[0] = OP_POINT;
      end else if (scheme_ff == SCHEME_BSPLINE) begin
         if (seen_ff == SEEN_ONE) begin
            push_cmd.ops[0] = req_bus.point_last ? OP_POINT : OP_MID;
         end else begin
            push_cmd.ops[0]    = OP_SMOOTH;
            push_cmd.ops[1]    = OP_MID;
            push_cmd.ops[2]    = OP_POINT;
            push_cmd.final_idx = req_bus.point_last ? IDX_W'(2) : IDX_W'(1);
         end
      end else begin
         if (seen_ff == SEEN_ONE) begin
            push_cmd.ops[0]    = OP_MID;
            push_cmd.ops[1]    = OP_POINT;
            push_cmd.final_idx = IDX_W'(1);
            push_valid         = req_bus.valid && req_bus.point_last;
         end else begin
            push_cmd.ops[0]    = OP_INS_LO;
            push_cmd.ops[1]    = OP_PREV;
            push_cmd.ops[2]    = OP_INS_HI;
            push_cmd.ops[3]    = OP_POINT;
            push_cmd.final_idx = req_bus.point_last ? IDX_W'(3) : IDX_W'(1);
         end
      end
   end

   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         if (req_bus.point_last) begin
            seen_in = SEEN_NONE;
         end else if (seen_ff != SEEN_MANY) begin
            seen_in = seen_ff + 2'd1;
         end
      end
      scheme_in = csr_bus.valid ? csr_bus.data : scheme_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= SEEN_NONE;
         scheme_ff <= SCHEME_BSPLINE;
      end else begin
         seen_ff   <= seen_in;
         scheme_ff <= scheme_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_x_ff[2] <= win_x_ff[1];
         win_x_ff[1] <= win_x_ff[0];
         win_x_ff[0] <= req_bus.point_x;
         win_y_ff[2] <= win_y_ff[1];
         win_y_ff[1] <= win_y_ff[0];
         win_y_ff[0] <= req_bus.point_y;
      end
   end

endmodule

// File: src/csd_queue.sv
// ----------------------------------------------------------------------------
// csd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: src/csd_back.sv
// ----------------------------------------------------------------------------
// csd_back
// Works through each queued command, one refined point per cycle while the
// receiver takes results, into a registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csd_back
   import csd_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_valid,
   input  cmd_type                                q_cmd,
   input  logic [POINT_SLOTS*(COORD_WIDTH+2)-1:0] q_data,
   output logic                                   q_ready,
   csd_rsp_if.source                              rsp_bus
);

   localparam int E = COORD_WIDTH + 2;
   localparam int W = COORD_WIDTH + 8;
   localparam logic signed [W-1:0] SAT_HI = {{(W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [W-1:0] SAT_LO = {{(W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   function automatic logic signed [COORD_WIDTH-1:0] refine(
      input op_type op,
      input logic signed [E-1:0] a_e,
      input logic signed [E-1:0] b_e,
      input logic signed [E-1:0] c_e,
      input logic signed [E-1:0] d_e,
      input logic signed [E-1:0] g_e
   );
      logic signed [W-1:0] a, b, c, d, g, res;
      a = W'(a_e);
      b = W'(b_e);
      c = W'(c_e);
      d = W'(d_e);
      g = W'(g_e);
      case (op)
         OP_POINT:  res = d;
         OP_PREV:   res = c;
         OP_MID:    res = (c + d) >>> 1;
         OP_SMOOTH: res = (b + (c <<< 2) + (c <<< 1) + d) >>> 3;
         OP_INS_LO: res = ((((b + c) <<< 3) + (b + c)) - a - d) >>> 4;
         OP_INS_HI: res = ((((c + d) <<< 3) + (c + d)) - b - g) >>> 4;
         default:   res = d;
      endcase
      if (res > SAT_HI) begin
         res = SAT_HI;
      end else if (res < SAT_LO) begin
         res = SAT_LO;
      end
      return res[COORD_WIDTH-1:0];
   endfunction

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic out_valid_ff, out_valid_in;
   logic signed [COORD_WIDTH-1:0] out_x_ff, out_y_ff;
   logic out_last_ff;
   logic advance, is_final;
   op_type op;

   assign advance  = q_valid && (!out_valid_ff || rsp_bus.ready);
   assign is_final = idx_ff == q_cmd.final_idx;
   assign q_ready  = advance && is_final;
   assign op       = q_cmd.ops[idx_ff];

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.out_x    = out_x_ff;
   assign rsp_bus.out_y    = out_y_ff;
   assign rsp_bus.out_last = out_last_ff;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         idx_in       = is_final ? '0 : idx_ff + IDX_W'(1);
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff <= refine(op, q_data[0*E +: E], q_data[2*E +: E], q_data[4*E +: E],
                            q_data[6*E +: E], q_data[8*E +: E]);
         out_y_ff <= refine(op, q_data[1*E +: E], q_data[3*E +: E], q_data[5*E +: E],
                            q_data[7*E +: E], q_data[9*E +: E]);
         out_last_ff <= q_cmd.last && is_final;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> idx_ff <= q_cmd.final_idx)
      else $error("result index ran past the command's last point");

   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> idx_ff == '0)
      else $error("result index not at zero with no command waiting");

   a_pop_restarts: assert property (@(posedge clock) disable iff (reset)
      q_ready |=> idx_ff == '0)
      else $error("result index did not restart after a command finished");

endmodule

// File: src/curve_subdivision_stream.sv
// ----------------------------------------------------------------------------
// curve_subdivision_stream
// One pass of cubic B-spline or four-point polyline subdivision, streamed.
// ----------------------------------------------------------------------------
// Control points enter on req_bus, one item per point, with point_last set on
// the final point of a polyline. Refined points leave on rsp_bus in order,
// out_last marking the final refined point. csr_bus writes the scheme
// register (0 cubic B-spline, 1 four-point); it is always ready and should be
// written only while no item is in flight.
// The front takes one control point per cycle while the queue has room and
// queues a command holding the points it needs; a four-entry queue lets it
// run ahead of the back. The back emits one refined point per cycle while
// the receiver is ready, from a registered output; a control point yields
// zero to four results, about two sustained. The first result of an item
// passes through the queue and then the output register before it is valid.
// When the receiver stalls, the output holds, the back stops and the queue
// fills; req_bus.ready drops only when the queue is full.
// Synchronous reset empties the queue and the output, restarts the polyline
// and selects the cubic B-spline scheme.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module curve_subdivision_stream
   import csd_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic      clock,
   input  logic      reset,
   csd_req_if.sink   req_bus,
   csd_rsp_if.source rsp_bus,
   csd_csr_if.sink   csr_bus
);

   localparam int DATA_W = POINT_SLOTS * (COORD_WIDTH + 2);
   localparam int CMD_W  = $bits(cmd_type);
   localparam int WORD_W = DATA_W + CMD_W;

   logic              push_valid, push_ready;
   cmd_type           push_cmd;
   logic [DATA_W-1:0] push_data;
   logic              q_valid, q_ready;
   logic [WORD_W-1:0] q_word;
   cmd_type           q_cmd;
   logic [DATA_W-1:0] q_data;

   csd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   csd_queue #(.WIDTH(WORD_W), .DEPTH(4)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_cmd, push_data}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_word)
   );

   assign q_cmd  = cmd_type'(q_word[DATA_W +: CMD_W]);
   assign q_data = q_word[DATA_W-1:0];

   csd_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_data  (q_data),
      .q_ready (q_ready),
      .rsp_bus (rsp_bus)
   );

endmodule
